// File: rtl/dil_pkg.sv
package dil_pkg;

  // Pixel and register field widths
  localparam int PIX_W    = 8;
  localparam int CFG_WD_W = 11;
  localparam int CFG_HT_W = 13;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Register reset values
  localparam logic [CFG_WD_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_HT_W-1:0] HEIGHT_RESET = 13'd480;

  // Value that spreads into its neighborhood
  localparam logic [PIX_W-1:0] FULL_VALUE = 8'd255;

  // Request kind
  localparam logic REQ_FLUSH = 1'b1;

  // Register index (paddr bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;

  // One line buffer entry: row two above and row just above
  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_pair_t;

  // Per-request control handed from position tracking to the window stage
  typedef struct packed {
    pixel_t pix;
    logic   up_ok;
    logic   mid_ok;
    logic   emit;
    logic   interior;
    logic   last;
  } item_t;

endpackage

// File: rtl/dil_in_if.sv
interface dil_in_if;
  logic            valid;
  logic            ready;
  logic            req_type;
  dil_pkg::pixel_t in_pixel;

  modport source (output valid, req_type, in_pixel, input ready);
  modport sink (input valid, req_type, in_pixel, output ready);
endinterface

// File: rtl/dil_out_if.sv
interface dil_out_if;
  logic            valid;
  logic            ready;
  dil_pkg::pixel_t out_pixel;
  logic            frame_last;

  modport source (output valid, out_pixel, frame_last, input ready);
  modport sink (input valid, out_pixel, frame_last, output ready);
endinterface

// File: rtl/dil_ram.sv
module dil_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; a read of the entry being written returns the old data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/dil_ctrl.sv
module dil_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int WW    = $clog2(MAX_WIDTH + 1),
  localparam int HW    = $clog2(MAX_HEIGHT + 1),
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dil_pkg::CFG_WD_W-1:0]  cfg_width,
  input  logic [dil_pkg::CFG_HT_W-1:0]  cfg_height,
  input  logic                          restart,
  input  logic                          accept,
  input  logic                          req_type,
  input  dil_pkg::pixel_t               in_pixel,
  output logic                          take,
  output logic [COL_W-1:0]              addr,
  output dil_pkg::item_t                item
);

  logic [COL_W-1:0] in_column;
  logic [ROW_W-1:0] in_row;

  logic [WW-1:0]    eff_w;
  logic [HW-1:0]    eff_h;
  logic [ROW_W-1:0] h_ext;
  logic [WW-1:0]    col_ext;
  logic [WW-1:0]    col_inc;
  logic [ROW_W-1:0] orow;
  logic [WW-1:0]    ocol;
  logic             col_zero;
  logic             frame_open;
  logic             flush;
  logic             emit;
  logic             last;

  // Clamp the configured size into the supported range
  always_comb begin
    if (cfg_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg_width);
    end
    if (cfg_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(cfg_height);
    end
  end

  assign h_ext      = ROW_W'(eff_h);
  assign col_ext    = WW'(in_column);
  assign col_inc    = col_ext + WW'(1);
  assign col_zero   = (in_column == '0);
  assign frame_open = (in_row < h_ext);
  assign flush      = (req_type == dil_pkg::REQ_FLUSH);

  // Flush while frame pixels are still due is dropped without effect
  assign take = accept && !(frame_open && flush);

  // Output position trails the input by width + 1
  assign emit = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && !col_zero);
  assign orow = col_zero ? (in_row - ROW_W'(2)) : (in_row - ROW_W'(1));
  assign ocol = col_zero ? (eff_w - WW'(1)) : (col_ext - WW'(1));
  assign last = (orow == (h_ext - ROW_W'(1))) && (ocol == (eff_w - WW'(1)));

  always_comb begin
    item.pix      = frame_open ? in_pixel : '0;
    item.up_ok    = (in_row >= ROW_W'(2));
    item.mid_ok   = (in_row != '0);
    item.emit     = emit;
    item.last     = last;
    item.interior = (orow != '0) && (orow < (h_ext - ROW_W'(1))) &&
                    (ocol != '0) && (ocol < (eff_w - WW'(1)));
  end

  assign addr = in_column;

  // Input position; restarts after the last output and on any register write
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_column <= '0;
      in_row    <= '0;
    end else if (take) begin
      if (emit && last) begin
        in_column <= '0;
        in_row    <= '0;
      end else if (col_inc >= eff_w) begin
        in_column <= '0;
        in_row    <= in_row + ROW_W'(1);
      end else begin
        in_column <= in_column + COL_W'(1);
      end
    end
  end

endmodule

// File: rtl/dil_win.sv
module dil_win #(
  parameter int MAX_WIDTH = 1024,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [COL_W-1:0]     addr,
  input  dil_pkg::item_t       item,
  output logic                 ready,
  input  dil_pkg::line_pair_t  rd_data,
  output logic                 wr_en,
  output logic [COL_W-1:0]     wr_addr,
  output dil_pkg::line_pair_t  wr_data,
  dil_out_if.source            results
);

  logic                         s1_valid;
  logic [COL_W-1:0]             s1_addr;
  dil_pkg::item_t               s1_item;
  logic                         s1_fwd;
  dil_pkg::line_pair_t          fwd_data;
  dil_pkg::line_pair_t          mem_pair;
  dil_pkg::pixel_t              up;
  dil_pkg::pixel_t              mid;
  dil_pkg::pixel_t              center;
  dil_pkg::pixel_t              res;
  dil_pkg::pixel_t [2:0][2:0]   win_q;
  dil_pkg::pixel_t [2:0][2:0]   win_next;
  logic                         any_full;
  logic                         adv;

  // Stage 1 moves on whenever the output register is free or being drained
  assign adv   = !results.valid || results.ready;
  assign ready = !s1_valid || adv;

  // Line buffer data, forwarded when the previous request wrote the same entry
  assign mem_pair = s1_fwd ? fwd_data : rd_data;
  assign up       = s1_item.up_ok  ? mem_pair.upper  : '0;
  assign mid      = s1_item.mid_ok ? mem_pair.middle : '0;

  // Write back: rows shift down by one at this column
  assign wr_en          = s1_valid && adv;
  assign wr_addr        = s1_addr;
  assign wr_data.upper  = mid;
  assign wr_data.middle = s1_item.pix;

  // Shift the window left and load the new column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win_q[r][1];
      win_next[r][1] = win_q[r][2];
    end
    win_next[0][2] = up;
    win_next[1][2] = mid;
    win_next[2][2] = s1_item.pix;
  end

  // Dilation of a zero interior pixel
  always_comb begin
    any_full = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (win_next[r][c] == dil_pkg::FULL_VALUE) begin
          any_full = 1'b1;
        end
      end
    end
  end

  assign center = win_next[1][1];
  assign res    = ((center == '0) && s1_item.interior && any_full) ?
                  dil_pkg::FULL_VALUE : center;

  // Control: stage valid, window, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      win_q         <= '0;
      results.valid <= 1'b0;
    end else begin
      if (ready) begin
        s1_valid <= take;
      end
      if (wr_en) begin
        win_q <= win_next;
      end
      if (wr_en && s1_item.emit) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr  <= addr;
      s1_item  <= item;
      s1_fwd   <= wr_en && (wr_addr == addr);
      fwd_data <= wr_data;
    end
    if (wr_en && s1_item.emit) begin
      results.out_pixel  <= res;
      results.frame_last <= s1_item.last;
    end
  end

endmodule

// File: rtl/binary_dilation_3x3.sv
// Streaming 3x3 dilation of 255-valued pixels. The block takes one request per
// clock (a frame pixel or a flush tick) and puts out at most one pixel per
// clock, so it sustains one pixel per cycle while the output is not stalled; a
// result passes through the stage 1 and output registers. Output trails input
// by width + 1 positions, so width + 1 flush ticks after the frame drain it,
// and the last pixel of the frame carries frame_last. Both line buffers share
// one MAX_WIDTH x 16 memory, read as a request is taken and written back as it
// leaves stage 1, with a bypass for back-to-back access to one entry. The memory
// needs no clearing after reset. Writing either register restarts the frame.
module binary_dilation_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  dil_in_if.sink                       pixels,
  dil_out_if.source                    results,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dil_pkg::APB_AW-1:0]   paddr,
  input  logic [dil_pkg::APB_DW-1:0]   pwdata,
  output logic [dil_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [dil_pkg::CFG_WD_W-1:0] cfg_width;
  logic [dil_pkg::CFG_HT_W-1:0] cfg_height;
  logic                         cfg_wr;
  logic                         accept;
  logic                         take;
  logic [COL_W-1:0]             addr;
  dil_pkg::item_t               item;
  logic                         ram_wr_en;
  logic [COL_W-1:0]             ram_wr_addr;
  dil_pkg::line_pair_t          ram_wr_data;
  dil_pkg::line_pair_t          ram_rd_data;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= dil_pkg::WIDTH_RESET;
      cfg_height <= dil_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        dil_pkg::REG_WIDTH:  cfg_width  <= pwdata[dil_pkg::CFG_WD_W-1:0];
        dil_pkg::REG_HEIGHT: cfg_height <= pwdata[dil_pkg::CFG_HT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      dil_pkg::REG_WIDTH:  prdata = dil_pkg::APB_DW'(cfg_width);
      dil_pkg::REG_HEIGHT: prdata = dil_pkg::APB_DW'(cfg_height);
      default:             prdata = '0;
    endcase
  end

  assign accept = pixels.valid && pixels.ready;

  // Position tracking and request classification
  dil_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_width  (cfg_width),
    .cfg_height (cfg_height),
    .restart    (cfg_wr),
    .accept     (accept),
    .req_type   (pixels.req_type),
    .in_pixel   (pixels.in_pixel),
    .take       (take),
    .addr       (addr),
    .item       (item)
  );

  // Line buffers: upper and middle row side by side
  dil_ram #(
    .WIDTH ($bits(dil_pkg::line_pair_t)),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (take),
    .rd_addr (addr),
    .rd_data (ram_rd_data)
  );

  // Window, dilation and output register
  dil_win #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_win (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .addr    (addr),
    .item    (item),
    .ready   (pixels.ready),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .results (results)
  );

`ifndef SYNTH
  // Requests are held off only behind a full, stalled output register
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !pixels.ready |-> (results.valid && !results.ready))
    else $error("request stalled while output register can move");

  // A dropped flush leaves the line buffers alone
  a_drop_no_write: assert property (@(posedge clk) disable iff (rst)
    (accept && !take) |=> !ram_wr_en)
    else $error("line buffer written after a dropped flush");

  // A new result always comes from a request that just wrote back
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(ram_wr_en))
    else $error("result appeared without a write-back");
`endif

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dil_pkg::*;

  localparam int LINE_DEPTH   = 1024;
  localparam int ROW_LIMIT    = 4096;
  localparam int RANDOM_STEPS = 200;
  localparam int WIDE_EXTRA   = 8;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 1_000_000;

  localparam logic REQ_PIXEL = ~REQ_FLUSH;

  // One output pixel as it should arrive
  typedef struct packed {
    pixel_t pix;
    logic   last;
  } dilated_t;

  // Hand-written request; typed rows carry the pixel they must produce
  typedef struct packed {
    logic   req;
    pixel_t pix;
    logic   typed;
    pixel_t want_pix;
    logic   want_last;
  } probe_row_t;

  // 4x3 frame:
  //   255 254   1   0
  //     0   0   0 254
  //   128 127 254   1
  // The corner 255 spreads to the interior pixel below-right of it but not to
  // the border zero beside it; the other interior zero sees no 255. A flush
  // inside the frame is dropped, a pixel during the drain counts as a flush,
  // and a flush right after the frame's last pixel is dropped again.
  localparam probe_row_t PROBES [19] = '{
    '{REQ_PIXEL, FULL_VALUE, 1'b0, 8'd0, 1'b0},
    '{REQ_PIXEL, 8'd254, 1'b0, 8'd0, 1'b0},
    '{REQ_PIXEL, 8'd1, 1'b0, 8'd0, 1'b0},
    '{REQ_FLUSH, 8'hA5, 1'b0, 8'd0, 1'b0},
    '{REQ_PIXEL, 8'd0, 1'b0, 8'd0, 1'b0},
    '{REQ_PIXEL, 8'd0, 1'b0, 8'd0, 1'b0},
    '{REQ_PIXEL, 8'd0, 1'b1, FULL_VALUE, 1'b0},
    '{REQ_PIXEL, 8'd0, 1'b0, 8'd0, 1'b0},
    '{REQ_PIXEL, 8'd254, 1'b0, 8'd0, 1'b0},
    '{REQ_PIXEL, 8'd128, 1'b0, 8'd0, 1'b0},
    '{REQ_PIXEL, 8'd127, 1'b1, 8'd0, 1'b0},
    '{REQ_PIXEL, 8'd254, 1'b1, FULL_VALUE, 1'b0},
    '{REQ_PIXEL, 8'd1, 1'b1, 8'd0, 1'b0},
    '{REQ_FLUSH, 8'h5A, 1'b0, 8'd0, 1'b0},
    '{REQ_FLUSH, 8'hFF, 1'b0, 8'd0, 1'b0},
    '{REQ_PIXEL, FULL_VALUE, 1'b0, 8'd0, 1'b0},
    '{REQ_FLUSH, 8'h00, 1'b0, 8'd0, 1'b0},
    '{REQ_FLUSH, 8'h3C, 1'b1, 8'd1, 1'b1},
    '{REQ_FLUSH, 8'hC3, 1'b0, 8'd0, 1'b0}
  };

  logic                clk;
  logic                rst = 1'b1;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  dil_in_if  pixels_if ();
  dil_out_if results_if ();

  binary_dilation_3x3 uut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pixels_if),
    .results (results_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: registers, line buffers, window, frame position
  logic [CFG_WD_W-1:0] cfg_width  = WIDTH_RESET;
  logic [CFG_HT_W-1:0] cfg_height = HEIGHT_RESET;
  pixel_t              upper_line [LINE_DEPTH];
  pixel_t              middle_line [LINE_DEPTH];
  pixel_t              window [9];
  int unsigned         in_col;
  int unsigned         in_row;
  int unsigned         emitted;

  dilated_t            awaited_pixels [$];
  int unsigned         steps_taken;
  int unsigned         mismatches;
  int unsigned         cycles;
  int                  send_idle;
  int                  recv_idle;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // Watchdog
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("testbench failed");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  function automatic int unsigned frame_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > LINE_DEPTH) return LINE_DEPTH;
    return cfg_width;
  endfunction

  function automatic int unsigned frame_height();
    if (cfg_height == 0) return 1;
    if (cfg_height > ROW_LIMIT) return ROW_LIMIT;
    return cfg_height;
  endfunction

  // Advance the predictor by one request; reports whether it had any effect
  // and the pixel it puts out, if any
  task automatic dilate_step(input logic req, input pixel_t pix, output bit moved,
                             output bit has_res, output dilated_t res);
    int unsigned w, h, total, pos, c, ocol, orow;
    pixel_t      up, mid, p;
    bit          emit;
    w = frame_width();
    h = frame_height();
    total = w * h;
    pos = in_row * w + in_col;
    p = pix;
    moved = 1'b0;
    has_res = 1'b0;
    res = '0;
    // flush inside the frame is dropped; past the frame a pixel reads as zero
    if (pos < total && req == REQ_FLUSH) return;
    if (pos >= total) p = '0;
    moved = 1'b1;
    c = in_col % LINE_DEPTH;
    up = (in_row >= 2) ? upper_line[c] : '0;
    mid = (in_row >= 1) ? middle_line[c] : '0;
    upper_line[c] = mid;
    middle_line[c] = p;
    for (int r = 0; r < 3; r++) begin
      window[r*3]   = window[r*3+1];
      window[r*3+1] = window[r*3+2];
    end
    window[2] = up;
    window[5] = mid;
    window[8] = p;
    emit = (pos >= w + 1) && (emitted < total);
    if (in_col == 0) begin
      ocol = w - 1;
      orow = in_row - 2;
    end else begin
      ocol = in_col - 1;
      orow = in_row - 1;
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return;
    // interior zero turns full when any original neighbor is full
    res.pix = window[4];
    if (window[4] == '0 && orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w) begin
      for (int k = 0; k < 9; k++) begin
        if (window[k] == FULL_VALUE) res.pix = FULL_VALUE;
      end
    end
    res.last = (emitted + 1 == total);
    has_res = 1'b1;
    emitted++;
    if (res.last) begin
      in_col = 0;
      in_row = 0;
      emitted = 0;
    end
  endtask

  // Send one request and queue the pixel it should produce
  task automatic push_request(input logic req, input pixel_t pix, input logic typed = 1'b0,
                              input pixel_t want_pix = '0, input logic want_last = 1'b0);
    bit       took;
    bit       moved;
    bit       has_res;
    dilated_t res;
    if ($urandom_range(99) < send_idle) begin
      pixels_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    pixels_if.valid    <= 1'b1;
    pixels_if.req_type <= req;
    pixels_if.in_pixel <= pix;
    do begin
      @(negedge clk);
      took = pixels_if.ready;
      @(posedge clk);
    end while (!took);
    dilate_step(req, pix, moved, has_res, res);
    if (moved) steps_taken++;
    if (typed) awaited_pixels.push_back('{want_pix, want_last});
    else if (has_res) awaited_pixels.push_back(res);
  endtask

  // Stop sending and let every pending pixel come out
  task automatic await_idle();
    pixels_if.valid <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == REG_WIDTH) cfg_width = val[CFG_WD_W-1:0];
    else cfg_height = val[CFG_HT_W-1:0];
    in_col = 0;
    in_row = 0;
    emitted = 0;
  endtask

  task automatic check_reg(input logic idx, input logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    if (pready !== 1'b1) flag_mismatch("pready low during a read");
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== want)
      flag_mismatch($sformatf("register %0d read %0h, want %0h", idx, got, want));
  endtask

  task automatic configure(input int unsigned w, input int unsigned h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    check_reg(REG_WIDTH, APB_DW'(cfg_width));
    check_reg(REG_HEIGHT, APB_DW'(cfg_height));
  endtask

  // One frame of random content; a cut frame stops early and is not drained
  task automatic run_frame(input bit cut);
    int unsigned w, total, stop, style;
    pixel_t      p;
    w = frame_width();
    total = w * frame_height();
    stop = cut ? $urandom_range(total - 1) : total;
    style = $urandom_range(3);
    for (int unsigned i = 0; i < stop; i++) begin
      if ($urandom_range(19) == 0) push_request(REQ_FLUSH, pixel_t'($urandom_range(255)));
      case (style)
        0: p = ($urandom_range(15) == 0) ? FULL_VALUE : '0;
        1: p = ($urandom_range(3) == 0) ? '0 : ($urandom_range(5) == 0) ? '1 :
               pixel_t'($urandom_range(255));
        2: p = pixel_t'($urandom_range(255));
        default: p = ($urandom_range(3) == 0) ? '0 : FULL_VALUE;
      endcase
      push_request(REQ_PIXEL, p);
    end
    if (!cut) begin
      for (int unsigned i = 0; i <= w; i++) begin
        if ($urandom_range(9) == 0) push_request(REQ_PIXEL, pixel_t'($urandom_range(255)));
        else push_request(REQ_FLUSH, pixel_t'($urandom_range(255)));
      end
    end
  endtask

  // Output side: random stalls, compare each accepted pixel
  initial begin
    bit       got;
    pixel_t   px;
    logic     lst;
    dilated_t want;
    results_if.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      got = results_if.valid && results_if.ready;
      px = results_if.out_pixel;
      lst = results_if.frame_last;
      @(posedge clk);
      results_if.ready <= ($urandom_range(99) >= recv_idle);
      if (got) begin
        if (awaited_pixels.size() == 0) begin
          flag_mismatch($sformatf("unexpected pixel %0d last %0b", px, lst));
        end else begin
          want = awaited_pixels.pop_front();
          if (px !== want.pix)
            flag_mismatch($sformatf("out_pixel %0d, want %0d", px, want.pix));
          if (lst !== want.last)
            flag_mismatch($sformatf("frame_last %0b, want %0b", lst, want.last));
        end
      end
    end
  end

  // Main sequence
  initial begin
    int unsigned base;
    int unsigned prog;
    bit          cut;
    pixels_if.valid    <= 1'b0;
    pixels_if.req_type <= REQ_PIXEL;
    pixels_if.in_pixel <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    send_idle = 10;
    recv_idle = 67;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    foreach (window[i]) window[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register values after reset
    check_reg(REG_WIDTH, APB_DW'(WIDTH_RESET));
    check_reg(REG_HEIGHT, APB_DW'(HEIGHT_RESET));

    // directed frame
    configure(4, 3);
    foreach (PROBES[i])
      push_request(PROBES[i].req, PROBES[i].pix, PROBES[i].typed, PROBES[i].want_pix,
                   PROBES[i].want_last);
    await_idle();

    // extreme sizes: zero registers, then widest rows in the tallest frame,
    // cut just after the first outputs appear
    send_idle = 67;
    recv_idle = 10;
    configure(0, 0);
    run_frame(1'b0);
    await_idle();
    configure(2047, 8191);
    for (int unsigned i = 0; i < LINE_DEPTH + WIDE_EXTRA; i++)
      push_request(REQ_PIXEL, ($urandom_range(3) == 0) ? FULL_VALUE : '0);
    await_idle();

    // random frames, idling pattern changes by thirds
    base = steps_taken;
    cut = 1'b1;
    while (steps_taken - base < RANDOM_STEPS) begin
      prog = steps_taken - base;
      if (prog < RANDOM_STEPS / 3) begin
        send_idle = 10;
        recv_idle = 67;
      end else if (prog < 2 * RANDOM_STEPS / 3) begin
        send_idle = 67;
        recv_idle = 10;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (cut || $urandom_range(1) == 0) begin
        await_idle();
        configure(($urandom_range(19) == 0) ? 0 :
                  ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1),
                  ($urandom_range(19) == 0) ? 0 : $urandom_range(8, 1));
      end
      cut = ($urandom_range(9) == 0);
      run_frame(cut);
    end

    await_idle();
    if (mismatches == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
